// ----- rtl/emln_pkg.sv -----
// ----------------------------------------------------------------------------
// emln_pkg
// Shared types and constants for the edge midpoint / length / normal block.
// ----------------------------------------------------------------------------
package emln_pkg;

    // Control that travels along the cell chain with every transaction.
    typedef struct packed {
        logic en;     // chain advance enable
        logic valid;  // this stage holds a transaction
    } cell_ctrl_t;

    // Low bits of the square-root trial value: (root << 2) | 1.
    localparam logic [1:0] SQRT_TRIAL_TAIL = 2'b01;

endpackage

// ----- rtl/emln_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// emln_sqrt_cell
// One digit of the restoring integer square root; one root bit per cell.
// ----------------------------------------------------------------------------
module emln_sqrt_cell
    import emln_pkg::*;
#(
    parameter int RootW = 33,
    parameter int SideW = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctrl_t             ctrl_in,
    input  logic [2*RootW-1:0]     rad_in,
    input  logic [RootW+2:0]       rem_in,
    input  logic [RootW-1:0]       root_in,
    input  logic [SideW-1:0]       side_in,
    output logic                   valid_out,
    output logic [2*RootW-1:0]     rad_out,
    output logic [RootW+2:0]       rem_out,
    output logic [RootW-1:0]       root_out,
    output logic [SideW-1:0]       side_out
);

    localparam int RemW = RootW + 3;

    logic                 valid_reg;
    logic [2*RootW-1:0]   rad_reg,  rad_next;
    logic [RemW-1:0]      rem_reg,  rem_next;
    logic [RootW-1:0]     root_reg, root_next;
    logic [SideW-1:0]     side_reg;
    logic [RemW-1:0]      rem_sh;
    logic [RemW-1:0]      trial;

    always_comb begin
        // bring down the next two radicand bits
        rem_sh   = {rem_in[RemW-3:0], rad_in[2*RootW-1 -: 2]};
        trial    = {1'b0, root_in, SQRT_TRIAL_TAIL};
        rad_next = {rad_in[2*RootW-3:0], 2'b00};
        if (rem_sh >= trial) begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[RootW-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh;
            root_next = {root_in[RootW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

// ----- rtl/emln_div_cell.sv -----
// ----------------------------------------------------------------------------
// emln_div_cell
// One quotient bit of the two tangent divisions (x and y share the divisor).
// ----------------------------------------------------------------------------
module emln_div_cell
    import emln_pkg::*;
#(
    parameter int LenW  = 33,
    parameter int QuoW  = 17,
    parameter int SideW = 8,
    parameter bit First = 1'b0   // integer step: no shift of the remainder
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl_in,
    input  logic [LenW-1:0]    den_in,
    input  logic [LenW:0]      rem_x_in,
    input  logic [LenW:0]      rem_y_in,
    input  logic [QuoW-1:0]    quo_x_in,
    input  logic [QuoW-1:0]    quo_y_in,
    input  logic [SideW-1:0]   side_in,
    output logic               valid_out,
    output logic [LenW-1:0]    den_out,
    output logic [LenW:0]      rem_x_out,
    output logic [LenW:0]      rem_y_out,
    output logic [QuoW-1:0]    quo_x_out,
    output logic [QuoW-1:0]    quo_y_out,
    output logic [SideW-1:0]   side_out
);

    logic               valid_reg;
    logic [LenW-1:0]    den_reg;
    logic [LenW:0]      rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QuoW-1:0]    quo_x_reg, quo_x_next, quo_y_reg, quo_y_next;
    logic [SideW-1:0]   side_reg;
    logic [LenW:0]      sh_x, sh_y, den_ext;

    always_comb begin
        den_ext = {1'b0, den_in};
        sh_x    = First ? rem_x_in : {rem_x_in[LenW-1:0], 1'b0};
        sh_y    = First ? rem_y_in : {rem_y_in[LenW-1:0], 1'b0};
        if (sh_x >= den_ext) begin
            rem_x_next = sh_x - den_ext;
            quo_x_next = {quo_x_in[QuoW-2:0], 1'b1};
        end else begin
            rem_x_next = sh_x;
            quo_x_next = {quo_x_in[QuoW-2:0], 1'b0};
        end
        if (sh_y >= den_ext) begin
            rem_y_next = sh_y - den_ext;
            quo_y_next = {quo_y_in[QuoW-2:0], 1'b1};
        end else begin
            rem_y_next = sh_y;
            quo_y_next = {quo_y_in[QuoW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            den_reg   <= den_in;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign den_out   = den_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign quo_x_out = quo_x_reg;
    assign quo_y_out = quo_y_reg;
    assign side_out  = side_reg;

endmodule

// ----- rtl/edge_midpoint_length_normal.sv -----
// ----------------------------------------------------------------------------
// edge_midpoint_length_normal
// Midpoint, length, unit tangent and unit normal of a 2D fixed-point segment.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction in and one out per cycle when m_ready is
// high. The chain has three front stages (differences and midpoint,
// squares, sum of squares), COORD_WIDTH+1 square-root cells producing one
// root bit each, FRAC_BITS+1 divider cells producing one tangent bit each
// for x and y together, and the output register. The whole chain advances
// together; it holds while a result sits in the output register and
// m_ready is low. A zero-length edge gives degenerate = 1 and all-zero unit
// vectors.
// ----------------------------------------------------------------------------
module edge_midpoint_length_normal
    import emln_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_start_x,
    input  logic signed [COORD_WIDTH-1:0] s_start_y,
    input  logic signed [COORD_WIDTH-1:0] s_end_x,
    input  logic signed [COORD_WIDTH-1:0] s_end_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_mid_x,
    output logic signed [COORD_WIDTH-1:0] m_mid_y,
    output logic        [COORD_WIDTH:0]   m_seg_length,
    output logic signed [FRAC_BITS+1:0]   m_tangent_x,
    output logic signed [FRAC_BITS+1:0]   m_tangent_y,
    output logic signed [FRAC_BITS+1:0]   m_normal_x,
    output logic signed [FRAC_BITS+1:0]   m_normal_y,
    output logic                          m_degenerate
);

    localparam int CW    = COORD_WIDTH;
    localparam int LW    = CW + 1;          // difference magnitude / length
    localparam int RADW  = 2 * LW;          // sum of squares
    localparam int REMW  = LW + 3;          // square-root remainder
    localparam int QW    = FRAC_BITS + 1;   // tangent magnitude
    localparam int UW    = FRAC_BITS + 2;   // signed tangent
    localparam int DSIDW = 2 * CW + 2;      // signs and midpoint
    localparam int SSIDW = 2 * LW + DSIDW;  // plus magnitudes
    localparam int NDIV  = FRAC_BITS + 1;

    localparam logic [QW-1:0] UNIT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // global advance: move when the output slot is free or being drained
    logic       en;
    cell_ctrl_t ctl;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---- stage 0: differences, magnitudes, midpoint ----
    logic              v0_reg;
    logic [LW-1:0]     dx, dy, sum_x, sum_y;
    logic [LW-1:0]     mag_x0_reg, mag_y0_reg;
    logic              sgn_x0_reg, sgn_y0_reg;
    logic [CW-1:0]     mid_x0_reg, mid_y0_reg;

    always_comb begin
        dx    = {s_end_x[CW-1], s_end_x} - {s_start_x[CW-1], s_start_x};
        dy    = {s_end_y[CW-1], s_end_y} - {s_start_y[CW-1], s_start_y};
        sum_x = {s_end_x[CW-1], s_end_x} + {s_start_x[CW-1], s_start_x};
        sum_y = {s_end_y[CW-1], s_end_y} + {s_start_y[CW-1], s_start_y};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_x0_reg <= dx[LW-1] ? (~dx + 1'b1) : dx;
            mag_y0_reg <= dy[LW-1] ? (~dy + 1'b1) : dy;
            sgn_x0_reg <= dx[LW-1];
            sgn_y0_reg <= dy[LW-1];
            mid_x0_reg <= sum_x[LW-1:1];   // floor of half sum
            mid_y0_reg <= sum_y[LW-1:1];
        end
    end

    // ---- stage 1: squares ----
    logic              v1_reg;
    logic [RADW-1:0]   sq_x1_reg, sq_y1_reg;
    logic [SSIDW-1:0]  side1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x1_reg <= RADW'(mag_x0_reg * mag_x0_reg);
            sq_y1_reg <= RADW'(mag_y0_reg * mag_y0_reg);
            side1_reg <= {mag_x0_reg, mag_y0_reg, sgn_x0_reg, sgn_y0_reg,
                          mid_x0_reg, mid_y0_reg};
        end
    end

    // ---- stage 2: sum of squares (fits RADW bits) ----
    logic              v2_reg;
    logic [RADW-1:0]   rad2_reg;
    logic [SSIDW-1:0]  side2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad2_reg  <= sq_x1_reg + sq_y1_reg;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // ---- square-root chain ----
    logic [LW:0]                 sq_v;
    logic [LW:0][RADW-1:0]       sq_rad;
    logic [LW:0][REMW-1:0]       sq_rem;
    logic [LW:0][LW-1:0]         sq_root;
    logic [LW:0][SSIDW-1:0]      sq_side;

    assign sq_v[0]    = v2_reg;
    assign sq_rad[0]  = rad2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side2_reg;

    for (genvar i = 0; i < LW; i++) begin : g_sqrt
        cell_ctrl_t c;
        assign c.en    = en;
        assign c.valid = sq_v[i];
        emln_sqrt_cell #(
            .RootW (LW),
            .SideW (SSIDW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl_in   (c),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_v[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // ---- tangent division chain ----
    logic [NDIV:0]               dv_v;
    logic [NDIV:0][LW-1:0]       dv_den;
    logic [NDIV:0][LW:0]         dv_rem_x, dv_rem_y;
    logic [NDIV:0][QW-1:0]       dv_quo_x, dv_quo_y;
    logic [NDIV:0][DSIDW-1:0]    dv_side;

    assign dv_v[0]     = sq_v[LW];
    assign dv_den[0]   = sq_root[LW];
    assign dv_rem_x[0] = {1'b0, sq_side[LW][SSIDW-1 -: LW]};
    assign dv_rem_y[0] = {1'b0, sq_side[LW][SSIDW-LW-1 -: LW]};
    assign dv_quo_x[0] = '0;
    assign dv_quo_y[0] = '0;
    assign dv_side[0]  = sq_side[LW][DSIDW-1:0];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        cell_ctrl_t c;
        assign c.en    = en;
        assign c.valid = dv_v[j];
        emln_div_cell #(
            .LenW  (LW),
            .QuoW  (QW),
            .SideW (DSIDW),
            .First (j == 0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl_in   (c),
            .den_in    (dv_den[j]),
            .rem_x_in  (dv_rem_x[j]),
            .rem_y_in  (dv_rem_y[j]),
            .quo_x_in  (dv_quo_x[j]),
            .quo_y_in  (dv_quo_y[j]),
            .side_in   (dv_side[j]),
            .valid_out (dv_v[j+1]),
            .den_out   (dv_den[j+1]),
            .rem_x_out (dv_rem_x[j+1]),
            .rem_y_out (dv_rem_y[j+1]),
            .quo_x_out (dv_quo_x[j+1]),
            .quo_y_out (dv_quo_y[j+1]),
            .side_out  (dv_side[j+1])
        );
    end

    // ---- output stage: sign, saturation guard, degenerate case ----
    logic [QW-1:0]   qx_sat, qy_sat;
    logic [UW-1:0]   tx_next, ty_next;
    logic            sgn_x, sgn_y, degen;
    logic            m_valid_reg;
    logic [CW-1:0]   mid_x_reg, mid_y_reg;
    logic [LW-1:0]   len_reg;
    logic [UW-1:0]   tx_reg, ty_reg, nx_reg;
    logic            degen_reg;

    always_comb begin
        sgn_x  = dv_side[NDIV][DSIDW-1];
        sgn_y  = dv_side[NDIV][DSIDW-2];
        degen  = (dv_den[NDIV] == '0);
        qx_sat = (dv_quo_x[NDIV] > UNIT_ONE) ? UNIT_ONE : dv_quo_x[NDIV];
        qy_sat = (dv_quo_y[NDIV] > UNIT_ONE) ? UNIT_ONE : dv_quo_y[NDIV];
        tx_next = sgn_x ? (~{1'b0, qx_sat} + 1'b1) : {1'b0, qx_sat};
        ty_next = sgn_y ? (~{1'b0, qy_sat} + 1'b1) : {1'b0, qy_sat};
        if (degen) begin
            tx_next = '0;
            ty_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_v[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_x_reg <= dv_side[NDIV][2*CW-1:CW];
            mid_y_reg <= dv_side[NDIV][CW-1:0];
            len_reg   <= dv_den[NDIV];
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            nx_reg    <= ~ty_next + 1'b1;
            degen_reg <= degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mid_x      = mid_x_reg;
    assign m_mid_y      = mid_y_reg;
    assign m_seg_length = len_reg;
    assign m_tangent_x  = tx_reg;
    assign m_tangent_y  = ty_reg;
    assign m_normal_x   = nx_reg;
    assign m_normal_y   = tx_reg;
    assign m_degenerate = degen_reg;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_seg_length == '0 && m_tangent_x == '0
                                    && m_tangent_y == '0)
        else $error("degenerate result with nonzero length or tangent");

    a_normal_rot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_y == m_tangent_x
                    && m_normal_x == UW'(~m_tangent_y + 1'b1))
        else $error("normal is not the tangent rotated left");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tangent_x <= $signed({1'b0, UNIT_ONE})
                    && m_tangent_x >= -$signed({1'b0, UNIT_ONE}))
        else $error("tangent beyond unit magnitude");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");
`endif

endmodule

// ----- tb/edge_midpoint_length_normal_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_midpoint_length_normal_test
// Streams segments through the block and checks midpoint, length, unit
// tangent, unit normal and degenerate flag against an in-bench predictor.
// ----------------------------------------------------------------------------
module edge_midpoint_length_normal_test;
    import emln_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int PIPE_LATENCY = CW + FB + 6;
    localparam int STALL_LIMIT = 20000;
    localparam logic [FB+1:0] UNIT_ONE = 18'sd65536;

    typedef struct packed {
        logic signed [CW-1:0] mid_x;
        logic signed [CW-1:0] mid_y;
        logic [CW:0]          seg_length;
        logic signed [FB+1:0] tangent_x;
        logic signed [FB+1:0] tangent_y;
        logic signed [FB+1:0] normal_x;
        logic signed [FB+1:0] normal_y;
        logic                 degenerate;
    } edge_geom_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [CW-1:0] s_start_x, s_start_y, s_end_x, s_end_y;
    logic m_valid;
    logic m_ready;
    logic signed [CW-1:0] m_mid_x, m_mid_y;
    logic [CW:0] m_seg_length;
    logic signed [FB+1:0] m_tangent_x, m_tangent_y, m_normal_x, m_normal_y;
    logic m_degenerate;

    edge_midpoint_length_normal dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_end_x(s_end_x), .s_end_y(s_end_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mid_x(m_mid_x), .m_mid_y(m_mid_y), .m_seg_length(m_seg_length),
        .m_tangent_x(m_tangent_x), .m_tangent_y(m_tangent_y),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
        .m_degenerate(m_degenerate)
    );

    // Expected geometry, oldest first.
    edge_geom_t pending_geom[$];
    int errors = 0;
    int sent_count = 0;
    int checked_count = 0;
    int degenerate_count = 0;
    int idle_cycles = 0;
    // Receiver mode: 0 random stalls, 1 long hold-off, 2 always ready.
    int sink_mode = 0;
    int hold_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Floor square root of a 66-bit sum of squares, one root bit per step.
    function automatic logic [CW:0] floor_sqrt(input logic [2*CW+1:0] sq);
        logic [CW:0] root;
        logic [CW:0] cand;
        root = '0;
        for (int i = CW; i >= 0; i--) begin
            cand = root | ((CW+1)'(1) << i);
            if ({33'd0, cand} * {33'd0, cand} <= sq) root = cand;
        end
        return root;
    endfunction

    // Truncated d * 2^FB / len, saturated to +/- one, at 18 bits.
    function automatic logic [FB+1:0] unit_component(input logic signed [CW:0] d,
                                                     input logic [CW:0] len);
        logic [CW:0] mag;
        logic [CW+FB:0] q;
        logic [FB+1:0] m;
        mag = d[CW] ? -d : d;
        q = ({{FB{1'b0}}, mag} << FB) / {{FB{1'b0}}, len};
        m = (q > (CW+FB+1)'(65536)) ? UNIT_ONE : q[FB+1:0];
        return d[CW] ? -m : m;
    endfunction

    function automatic edge_geom_t predict_geometry(input logic signed [CW-1:0] sx,
                                                    input logic signed [CW-1:0] sy,
                                                    input logic signed [CW-1:0] ex,
                                                    input logic signed [CW-1:0] ey);
        edge_geom_t g;
        logic signed [CW:0] sum_x, sum_y, dx, dy;
        logic [CW:0] ax, ay;
        logic [2*CW+1:0] sq;
        sum_y = $signed({sy[CW-1], sy}) + $signed({ey[CW-1], ey});
        sum_x = $signed({sx[CW-1], sx}) + $signed({ex[CW-1], ex});
        dx = $signed({ex[CW-1], ex}) - $signed({sx[CW-1], sx});
        dy = $signed({ey[CW-1], ey}) - $signed({sy[CW-1], sy});
        ax = dx[CW] ? -dx : dx;
        ay = dy[CW] ? -dy : dy;
        sq = {33'd0, ax} * {33'd0, ax} + {33'd0, ay} * {33'd0, ay};
        g.mid_x = sum_x[CW:1];
        g.mid_y = sum_y[CW:1];
        g.seg_length = floor_sqrt(sq);
        if (g.seg_length == 0) begin
            g.tangent_x = '0;
            g.tangent_y = '0;
            g.degenerate = 1'b1;
        end else begin
            g.tangent_x = unit_component(dx, g.seg_length);
            g.tangent_y = unit_component(dy, g.seg_length);
            g.degenerate = 1'b0;
        end
        g.normal_x = -g.tangent_y;
        g.normal_y = g.tangent_x;
        return g;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one segment, hold it until accepted. Valid stays up after the
    // accept; wait_drained, or a gap in the next call, lowers it.
    task automatic send_segment(input logic signed [CW-1:0] sx,
                                input logic signed [CW-1:0] sy,
                                input logic signed [CW-1:0] ex,
                                input logic signed [CW-1:0] ey,
                                input bit with_gaps);
        int gap;
        gap = with_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_x <= sx;
        s_start_y <= sy;
        s_end_x <= ex;
        s_end_y <= ey;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_geom.push_back(predict_geometry(sx, sy, ex, ey));
        sent_count++;
    endtask

    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (pending_geom.size() != 0) @(posedge aclk);
    endtask

    // Coordinate biased toward extremes and small values.
    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 200) - 100;
            2: return 32'h7fff_ffff - $urandom_range(0, 3);
            3: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic test_directed();
        send_segment(0, 0, 0, 0, 0);
        send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0);
        send_segment(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0);
        send_segment(0, 32'h8000_0000, 0, 32'h7fff_ffff, 0);
        send_segment(0, 0, 1, 0, 0);
        send_segment(0, 0, 0, -1, 0);
        send_segment(0, 0, 1, 1, 0);
        send_segment(0, 0, 32'h0001_0000, 0, 0);
        send_segment(0, 0, 0, 32'h0001_0000, 0);
        send_segment(32'h0003_0000, 32'h0004_0000, 0, 0, 0);
        send_segment(-1, -1, 0, 0, 0);
        send_segment(-3, 5, -3, 5, 0);
        send_segment(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0);
        send_segment(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'h7654_3210, 0);
        wait_drained();
    endtask

    task automatic test_random_stream(input int count);
        logic [CW-1:0] sx, sy;
        for (int i = 0; i < count; i++) begin
            sx = rand_coord();
            sy = rand_coord();
            // Some zero-length edges and near-zero ones.
            case ($urandom_range(0, 9))
                0: send_segment(sx, sy, sx, sy, 1);
                1: send_segment(sx, sy, sx + $urandom_range(0, 2) - 1,
                                sy + $urandom_range(0, 2) - 1, 1);
                default: send_segment(sx, sy, rand_coord(), rand_coord(), 1);
            endcase
        end
    endtask

    // Back-to-back sends while the receiver holds off, to fill the pipe.
    task automatic test_backpressure();
        sink_mode = 1;
        for (int i = 0; i < 120; i++)
            send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
        wait_drained();
        sink_mode = 0;
    endtask

    task automatic test_full_rate();
        sink_mode = 2;
        for (int i = 0; i < 150; i++)
            send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
        wait_drained();
        sink_mode = 0;
    endtask

    // Receiver: random stalls, a long counted hold-off, or always ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cycles <= 0;
        end else if (sink_mode == 1) begin
            if (hold_cycles < 300) begin
                hold_cycles <= hold_cycles + 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end else if (sink_mode == 2) begin
            hold_cycles <= 0;
            m_ready <= 1'b1;
        end else begin
            hold_cycles <= 0;
            m_ready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 50 && m_ready);
        end
    end

    // Checker: compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        edge_geom_t exp_g;
        edge_geom_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_mid_x, m_mid_y, m_seg_length, m_tangent_x, m_tangent_y,
                    m_normal_x, m_normal_y, m_degenerate};
            if (pending_geom.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction %h", $time, got);
            end else begin
                exp_g = pending_geom.pop_front();
                checked_count++;
                if (exp_g.degenerate) degenerate_count++;
                if (got.mid_x !== exp_g.mid_x) begin
                    errors++;
                    $display("%0t: mid_x exp %h got %h", $time, exp_g.mid_x, got.mid_x);
                end
                if (got.mid_y !== exp_g.mid_y) begin
                    errors++;
                    $display("%0t: mid_y exp %h got %h", $time, exp_g.mid_y, got.mid_y);
                end
                if (got.seg_length !== exp_g.seg_length) begin
                    errors++;
                    $display("%0t: seg_length exp %h got %h", $time,
                             exp_g.seg_length, got.seg_length);
                end
                if (got.tangent_x !== exp_g.tangent_x) begin
                    errors++;
                    $display("%0t: tangent_x exp %h got %h", $time,
                             exp_g.tangent_x, got.tangent_x);
                end
                if (got.tangent_y !== exp_g.tangent_y) begin
                    errors++;
                    $display("%0t: tangent_y exp %h got %h", $time,
                             exp_g.tangent_y, got.tangent_y);
                end
                if (got.normal_x !== exp_g.normal_x) begin
                    errors++;
                    $display("%0t: normal_x exp %h got %h", $time,
                             exp_g.normal_x, got.normal_x);
                end
                if (got.normal_y !== exp_g.normal_y) begin
                    errors++;
                    $display("%0t: normal_y exp %h got %h", $time,
                             exp_g.normal_y, got.normal_y);
                end
                if (got.degenerate !== exp_g.degenerate) begin
                    errors++;
                    $display("%0t: degenerate exp %b got %b", $time,
                             exp_g.degenerate, got.degenerate);
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_geom.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_start_x = '0;
        s_start_y = '0;
        s_end_x = '0;
        s_end_y = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_stream(250);
        test_backpressure();
        // Sender pauses until the pipe is empty.
        wait_drained();
        test_full_rate();
        test_random_stream(230);

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        $display("Sent %0d segments, checked %0d results (%0d degenerate),",
                 sent_count, checked_count, degenerate_count);
        $display("with random gaps, a long receiver hold-off and a full-rate burst.");
        if (errors == 0 && pending_geom.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/emln_pkg.sv
rtl/emln_sqrt_cell.sv
rtl/emln_div_cell.sv
rtl/edge_midpoint_length_normal.sv
tb/edge_midpoint_length_normal_test.sv
